[sv/fpurs_pkg.sv]
package fpurs_pkg;

  // Largest stack the status word can describe: top pointer is 3 bits there
  localparam int SlotAddrW = 3;
  localparam int ValueW    = 80;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_READ   = 3'd2,
    ACT_WRITE  = 3'd3,
    ACT_STATUS = 3'd4,
    ACT_LOADCC = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_EMPTY     = 2'd1,
    ERR_PUSH_FULL = 2'd2,
    ERR_POP_EMPTY = 2'd3
  } error_t;

  // Register-file control from the stack controller
  typedef struct packed {
    logic                 wr_en;
    logic                 set_valid;
    logic                 clr_valid;
    logic [SlotAddrW-1:0] addr;
  } slot_ctl_t;

endpackage

[sv/fpurs_if.sv]
interface fpurs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  index;
  logic [63:0] value_mantissa;
  logic [15:0] value_sign_exponent;
  logic [15:0] status_in;

  modport source (
    output valid, action, index, value_mantissa, value_sign_exponent, status_in,
    input  ready
  );
  modport sink (
    input  valid, action, index, value_mantissa, value_sign_exponent, status_in,
    output ready
  );
endinterface

interface fpurs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_mantissa;
  logic [15:0] data_sign_exponent;
  logic [15:0] status_word;
  logic [1:0]  error;

  modport source (
    output valid, data_mantissa, data_sign_exponent, status_word, error,
    input  ready
  );
  modport sink (
    input  valid, data_mantissa, data_sign_exponent, status_word, error,
    output ready
  );
endinterface

[sv/fpurs_slots.sv]
module fpurs_slots #(
  parameter int STACK_DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fpurs_pkg::slot_ctl_t            ctl,
  input  logic [fpurs_pkg::ValueW-1:0]    wr_data,
  output logic                            rd_valid,
  output logic [fpurs_pkg::ValueW-1:0]    rd_data
);

  localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [STACK_DEPTH-1:0]         valid_r;
  logic [STACK_DEPTH-1:0]         valid_nxt;
  logic [fpurs_pkg::ValueW-1:0]   value_r [STACK_DEPTH];
  logic [AddrW-1:0]               addr;

  assign addr     = ctl.addr[AddrW-1:0];
  assign rd_valid = valid_r[addr];
  assign rd_data  = value_r[addr];

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.set_valid) begin
      valid_nxt[addr] = 1'b1;
    end else if (ctl.clr_valid) begin
      valid_nxt[addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // no reset: a slot is only read once its valid bit is set
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      value_r[addr] <= wr_data;
    end
  end

endmodule

[sv/fpu_register_stack_top.sv]
// Channel | Dir | Payload                                                  | Handshake
// in_ch   | in  | action, index, value_mantissa, value_sign_exponent,     | valid/ready
//         |     | status_in                                                |
// out_ch  | out | data_mantissa, data_sign_exponent, status_word, error    | valid/ready
//
// One operation per cycle while in_ch.ready is high: each transfer on in_ch is
// decoded, checked against the slot valid bits and applied to top, codes and
// slots in that same cycle, while its result is registered in the output register.
// The rate is set by the single register-file access.
// rst_n (synchronous, active low) clears top, codes, slot valid bits and the
// output valid flag. Slot values and output data are not cleared.
// in_ch.ready stays high while the output register is empty or being drained,
// so a waiting result never blocks a transfer that frees it in the same cycle.
module fpu_register_stack_top #(
  parameter int STACK_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  fpurs_in_if.sink           in_ch,
  fpurs_out_if.source        out_ch
);

  localparam int TopW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // (top + i) wrapped to the stack depth; sum is at most 14, so seven
  // conditional subtracts cover every depth from 2 to 8
  function automatic logic [3:0] wrap_pos(input logic [3:0] pos);
    logic [3:0] w;
    w = pos;
    for (int k = 0; k < 7; k++) begin
      if (w >= 4'(STACK_DEPTH)) begin
        w = w - 4'(STACK_DEPTH);
      end
    end
    return w;
  endfunction

  // architectural state
  logic [TopW-1:0] top_r;
  logic [TopW-1:0] top_nxt;
  logic [3:0]      cc_r;
  logic [3:0]      cc_nxt;

  // output register
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [63:0]     data_mant_r;
  logic [15:0]     data_sexp_r;
  logic [15:0]     status_r;
  logic [1:0]      error_r;

  logic                           accept;
  logic [3:0]                     acc_pos;
  logic [TopW-1:0]                acc_slot;
  logic [TopW-1:0]                push_slot;
  logic [TopW-1:0]                slot;
  logic [TopW-1:0]                pop_next;
  fpurs_pkg::slot_ctl_t           ctl;
  logic                           rd_valid;
  logic [fpurs_pkg::ValueW-1:0]   rd_data;
  logic [fpurs_pkg::ValueW-1:0]   wr_data;
  logic [63:0]                    res_mant;
  logic [15:0]                    res_sexp;
  logic [15:0]                    res_status;
  fpurs_pkg::error_t              res_err;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign acc_pos   = wrap_pos(4'(top_r) + {1'b0, in_ch.index});
  assign acc_slot  = acc_pos[TopW-1:0];
  assign push_slot = (top_r == '0) ? TopW'(STACK_DEPTH - 1) : top_r - TopW'(1);
  assign pop_next  = (top_r == TopW'(STACK_DEPTH - 1)) ? '0 : top_r + TopW'(1);
  assign wr_data   = {in_ch.value_sign_exponent, in_ch.value_mantissa};

  always_comb begin
    case (in_ch.action)
      fpurs_pkg::ACT_PUSH:  slot = push_slot;
      fpurs_pkg::ACT_POP:   slot = top_r;
      default:              slot = acc_slot;
    endcase
  end

  always_comb begin
    top_nxt       = top_r;
    cc_nxt        = cc_r;
    ctl           = '0;
    ctl.addr      = fpurs_pkg::SlotAddrW'(slot);
    res_mant      = '0;
    res_sexp      = '0;
    res_err       = fpurs_pkg::ERR_OK;
    case (in_ch.action)
      fpurs_pkg::ACT_PUSH: begin
        if (rd_valid) begin
          res_err = fpurs_pkg::ERR_PUSH_FULL;
        end else begin
          top_nxt       = push_slot;
          ctl.wr_en     = accept;
          ctl.set_valid = accept;
        end
      end
      fpurs_pkg::ACT_POP: begin
        if (!rd_valid) begin
          res_err = fpurs_pkg::ERR_POP_EMPTY;
        end else begin
          res_mant      = rd_data[63:0];
          res_sexp      = rd_data[79:64];
          ctl.clr_valid = accept;
          top_nxt       = pop_next;
        end
      end
      fpurs_pkg::ACT_READ: begin
        if (!rd_valid) begin
          res_err = fpurs_pkg::ERR_EMPTY;
        end else begin
          res_mant = rd_data[63:0];
          res_sexp = rd_data[79:64];
        end
      end
      fpurs_pkg::ACT_WRITE: begin
        if (!rd_valid) begin
          res_err = fpurs_pkg::ERR_EMPTY;
        end else begin
          ctl.wr_en = accept;
        end
      end
      fpurs_pkg::ACT_LOADCC: begin
        cc_nxt = {in_ch.status_in[14], in_ch.status_in[10:8]};
      end
      default: begin
        // status read and unused codes leave the state alone
      end
    endcase
    // status reflects the state after this operation
    res_status = {1'b0, cc_nxt[3], 3'(top_nxt), cc_nxt[2:0], 8'h00};
  end

  fpurs_slots #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      cc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        top_r <= top_nxt;
        cc_r  <= cc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_mant_r <= res_mant;
      data_sexp_r <= res_sexp;
      status_r    <= res_status;
      error_r     <= res_err;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.data_mantissa      = data_mant_r;
  assign out_ch.data_sign_exponent = data_sexp_r;
  assign out_ch.status_word        = status_r;
  assign out_ch.error              = error_r;

endmodule
